>>> rtl/core/rrst_pkg.sv
// ----------------------------------------------------------------------------
// Route retry slot table package
// Shared constants, codes, record types and controller states.
// ----------------------------------------------------------------------------
package rrst_pkg;

	// Table geometry.
	localparam int SLOT_COUNT = 16;
	localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	// Widths of stored times and of configuration registers.
	localparam int TIME_W = 49;
	localparam int NOW_W  = 48;
	localparam int CFG_W  = 32;

	// Result codes.
	localparam logic [2:0] RC_ACQUIRED    = 3'd0;
	localparam logic [2:0] RC_PENDING     = 3'd1;
	localparam logic [2:0] RC_DEFERRED    = 3'd2;
	localparam logic [2:0] RC_BUSY        = 3'd3;
	localparam logic [2:0] RC_MISMATCH    = 3'd4;
	localparam logic [2:0] RC_DOWNGRADE   = 3'd5;
	localparam logic [2:0] RC_EXHAUSTED   = 3'd6;
	localparam logic [2:0] RC_UNAVAILABLE = 3'd7;

	// Observation codes.
	localparam logic [2:0] OBS_CONNECTING = 3'd1;
	localparam logic [2:0] OBS_MATCHED    = 3'd2;
	localparam logic [2:0] OBS_WRONG      = 3'd3;
	localparam logic [2:0] OBS_PLAIN      = 3'd4;

	// Operation codes.
	localparam logic OP_STEP  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] CFG_LIFETIME  = 2'd0;
	localparam logic [1:0] CFG_RETENTION = 2'd1;
	localparam logic [1:0] CFG_LIMIT     = 2'd2;
	localparam logic [1:0] CFG_BACKOFF   = 2'd3;

	// One stored slot; the used flag lives in flops beside the memory.
	typedef struct packed {
		logic              terminal;
		logic [2:0]        code;
		logic [63:0]       key;
		logic [63:0]       endpoint;
		logic [TIME_W-1:0] deadline;
		logic [TIME_W-1:0] next_try;
		logic [4:0]        attempts;
	} slot_rec_t;

	// Requests from the controller to the slot store.
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic             wr_en;
		logic [IDX_W-1:0] wr_idx;
		slot_rec_t        wr_data;
		logic             used_we;
		logic [IDX_W-1:0] used_idx;
		logic             used_val;
		logic             clr_all;
	} store_req_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_APPLY,
		ST_OUT
	} state_t;

endpackage

>>> rtl/core/route_retry_slot_table.sv
// ----------------------------------------------------------------------------
// Route retry slot table
// Pairing-keyed route slots with expiry, terminal latching and hint backoff.
// ----------------------------------------------------------------------------
// One item is handled at a time. A clear or a step at time zero offers its
// result beat in the cycle after it is taken. A step reads the slot memory one
// slot at a time, first in a read state and then in an evaluate state, and
// stops at the first slot holding its key; an apply state then applies the
// observation and writes the slot back, unless no slot matched and none was
// free. The slot memory has a single read port. The next item is taken at the
// earliest in the cycle after the result beat is taken.
// The used flags reset at once, so no clearing pass follows reset.
module route_retry_slot_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [63:0] pairing_key,
	input  logic [63:0] endpoint_key,
	input  logic [2:0]  observation,
	input  logic        resource_grant,
	input  logic        hint_accepted,
	input  logic [47:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  result_code,
	output logic [4:0]  attempt_count,
	output logic        hint_issue,
	output logic [63:0] hint_endpoint
);

	logic [31:0] lifetime_q, retention_q;
	logic [4:0]  limit_q;
	logic [15:0] backoff_q;

	rrst_pkg::store_req_t req;
	rrst_pkg::slot_rec_t  rd_data;
	logic [rrst_pkg::SLOT_COUNT-1:0] used;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q  <= 32'd60000;
			retention_q <= 32'd30000;
			limit_q     <= 5'd4;
			backoff_q   <= 16'd1000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				rrst_pkg::CFG_LIFETIME:  lifetime_q  <= cfg_data;
				rrst_pkg::CFG_RETENTION: retention_q <= cfg_data;
				rrst_pkg::CFG_LIMIT:     limit_q     <= cfg_data[4:0];
				rrst_pkg::CFG_BACKOFF:   backoff_q   <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	rrst_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data),
		.used    (used)
	);

	rrst_ctrl u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.operation         (operation),
		.pairing_key       (pairing_key),
		.endpoint_key      (endpoint_key),
		.observation       (observation),
		.resource_grant    (resource_grant),
		.hint_accepted     (hint_accepted),
		.now_ms            (now_ms),
		.lifetime          (lifetime_q),
		.retention         (retention_q),
		.limit             (limit_q),
		.backoff           (backoff_q),
		.req               (req),
		.rd_data           (rd_data),
		.used              (used),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.result_code       (result_code),
		.attempt_count     (attempt_count),
		.hint_issue        (hint_issue),
		.hint_endpoint     (hint_endpoint)
	);

endmodule

>>> rtl/core/rrst_store.sv
// ----------------------------------------------------------------------------
// Route retry slot store
// Slot record memory with a registered read port, plus per-slot used flags.
// ----------------------------------------------------------------------------
module rrst_store (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rrst_pkg::store_req_t             req,
	output rrst_pkg::slot_rec_t              rd_data,
	output logic [rrst_pkg::SLOT_COUNT-1:0]  used
);

	rrst_pkg::slot_rec_t mem [rrst_pkg::SLOT_COUNT];
	rrst_pkg::slot_rec_t rd_data_q;
	logic [rrst_pkg::SLOT_COUNT-1:0] used_q;

	// Record memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_idx] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_idx];
		end
	end

	// Used flags; a slot that is not used holds no meaningful record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (req.clr_all) begin
			used_q <= '0;
		end else if (req.used_we) begin
			used_q[req.used_idx] <= req.used_val;
		end
	end

	assign rd_data = rd_data_q;
	assign used    = used_q;

endmodule

>>> rtl/core/rrst_ctrl.sv
// ----------------------------------------------------------------------------
// Route retry slot controller
// Scans the slots one by one, picks a slot, applies the observation and
// holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module rrst_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             operation,
	input  logic [63:0]                      pairing_key,
	input  logic [63:0]                      endpoint_key,
	input  logic [2:0]                       observation,
	input  logic                             resource_grant,
	input  logic                             hint_accepted,
	input  logic [rrst_pkg::NOW_W-1:0]       now_ms,
	input  logic [rrst_pkg::CFG_W-1:0]       lifetime,
	input  logic [rrst_pkg::CFG_W-1:0]       retention,
	input  logic [4:0]                       limit,
	input  logic [15:0]                      backoff,
	output rrst_pkg::store_req_t             req,
	input  rrst_pkg::slot_rec_t              rd_data,
	input  logic [rrst_pkg::SLOT_COUNT-1:0]  used,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [2:0]                       result_code,
	output logic [4:0]                       attempt_count,
	output logic                             hint_issue,
	output logic [63:0]                      hint_endpoint
);

	localparam int TW = rrst_pkg::TIME_W;

	rrst_pkg::state_t state_q, state_d;

	// Latched item.
	logic [63:0]   key_q, ep_q;
	logic [2:0]    obs_q;
	logic          adm_q, acc_q;
	logic [TW-1:0] now_q, alloc_dl_q, term_dl_q;

	// Scan state.
	logic [rrst_pkg::IDX_W-1:0] idx_q, free_idx_q, sel_idx_q;
	logic                       free_found_q;
	rrst_pkg::slot_rec_t        cur_q;

	// Result register.
	logic [2:0]  code_q;
	logic [4:0]  att_q;
	logic        hint_q;
	logic [63:0] hep_q;

	logic accept;
	logic is_last;
	logic hit, replace, expired, take_free;
	logic free_found_d;
	logic [rrst_pkg::IDX_W-1:0] free_idx_d;
	rrst_pkg::slot_rec_t fresh;
	rrst_pkg::slot_rec_t upd;
	logic        upd_used, upd_hint;
	logic [2:0]  upd_code;

	assign accept  = in_valid && !in_stall;
	assign is_last = (idx_q == rrst_pkg::IDX_W'(rrst_pkg::SLOT_COUNT - 1));

	// Slot evaluation during the scan.
	always_comb begin
		hit     = used[idx_q] && (rd_data.key == key_q);
		replace = hit && ((rd_data.terminal && (now_q >= rd_data.deadline)) ||
			(rd_data.endpoint != ep_q));
		expired = !hit && used[idx_q] && (now_q >= rd_data.deadline);
		take_free = (expired || !used[idx_q]) && !free_found_q;
		free_found_d = free_found_q || take_free;
		free_idx_d   = take_free ? idx_q : free_idx_q;
		fresh = '{terminal: 1'b0, code: 3'd0, key: key_q, endpoint: ep_q,
			deadline: alloc_dl_q, next_try: '0, attempts: 5'd0};
	end

	// Observation applied to the chosen slot.
	always_comb begin
		upd      = cur_q;
		upd_used = 1'b1;
		upd_hint = 1'b0;
		upd_code = rrst_pkg::RC_PENDING;
		priority if (cur_q.terminal) begin
			upd_code = cur_q.code;
		end else if (obs_q == rrst_pkg::OBS_MATCHED) begin
			upd_used = 1'b0;
			upd_code = rrst_pkg::RC_ACQUIRED;
		end else if (obs_q == rrst_pkg::OBS_WRONG || obs_q == rrst_pkg::OBS_PLAIN) begin
			upd_code = (obs_q == rrst_pkg::OBS_WRONG) ? rrst_pkg::RC_MISMATCH
				: rrst_pkg::RC_DOWNGRADE;
			upd.terminal = 1'b1;
			upd.code     = upd_code;
			upd.deadline = term_dl_q;
		end else if (obs_q == rrst_pkg::OBS_CONNECTING) begin
			upd_code = rrst_pkg::RC_PENDING;
		end else if (now_q >= cur_q.deadline) begin
			upd_code = rrst_pkg::RC_EXHAUSTED;
			upd.terminal = 1'b1;
			upd.code     = rrst_pkg::RC_EXHAUSTED;
			upd.deadline = term_dl_q;
		end else if (cur_q.attempts >= limit) begin
			upd_code = rrst_pkg::RC_PENDING;
		end else if (now_q < cur_q.next_try) begin
			upd_code = rrst_pkg::RC_PENDING;
		end else if (!adm_q || !acc_q) begin
			upd_code = rrst_pkg::RC_DEFERRED;
		end else begin
			upd_hint      = 1'b1;
			upd.attempts  = cur_q.attempts + 5'd1;
			upd.next_try  = now_q + (TW'(backoff) << cur_q.attempts);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rrst_pkg::ST_IDLE: begin
				if (accept) begin
					if (operation == rrst_pkg::OP_CLEAR || now_ms == '0) begin
						state_d = rrst_pkg::ST_OUT;
					end else begin
						state_d = rrst_pkg::ST_READ;
					end
				end
			end
			rrst_pkg::ST_READ: begin
				state_d = rrst_pkg::ST_EVAL;
			end
			rrst_pkg::ST_EVAL: begin
				if (hit && !replace) begin
					state_d = rrst_pkg::ST_APPLY;
				end else if (replace) begin
					state_d = rrst_pkg::ST_APPLY;
				end else if (is_last) begin
					state_d = free_found_d ? rrst_pkg::ST_APPLY : rrst_pkg::ST_OUT;
				end else begin
					state_d = rrst_pkg::ST_READ;
				end
			end
			rrst_pkg::ST_APPLY: begin
				state_d = rrst_pkg::ST_OUT;
			end
			rrst_pkg::ST_OUT: begin
				if (!out_stall) begin
					state_d = rrst_pkg::ST_IDLE;
				end
			end
			default: state_d = rrst_pkg::ST_IDLE;
		endcase
	end

	// Store requests.
	always_comb begin
		req = '0;
		req.rd_idx   = idx_q;
		req.wr_idx   = sel_idx_q;
		req.wr_data  = upd;
		req.used_idx = idx_q;
		unique case (state_q)
			rrst_pkg::ST_IDLE: begin
				req.clr_all = accept && (operation == rrst_pkg::OP_CLEAR);
			end
			rrst_pkg::ST_READ: begin
				req.rd_en = 1'b1;
			end
			rrst_pkg::ST_EVAL: begin
				// Expired slots ahead of the match are freed.
				req.used_we  = expired;
				req.used_val = 1'b0;
			end
			rrst_pkg::ST_APPLY: begin
				req.wr_en    = 1'b1;
				req.used_we  = 1'b1;
				req.used_idx = sel_idx_q;
				req.used_val = upd_used;
			end
			rrst_pkg::ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= rrst_pkg::ST_IDLE;
			idx_q        <= '0;
			free_found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == rrst_pkg::ST_IDLE) begin
				idx_q        <= '0;
				free_found_q <= 1'b0;
			end else if (state_q == rrst_pkg::ST_EVAL) begin
				free_found_q <= free_found_d;
				if (!is_last) begin
					idx_q <= idx_q + rrst_pkg::IDX_W'(1);
				end
			end
		end
	end

	// Item, slot and result registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			rrst_pkg::ST_IDLE: begin
				if (accept) begin
					key_q      <= pairing_key;
					ep_q       <= endpoint_key;
					obs_q      <= observation;
					adm_q      <= resource_grant;
					acc_q      <= hint_accepted;
					now_q      <= TW'(now_ms);
					alloc_dl_q <= TW'(now_ms) + TW'(lifetime);
					term_dl_q  <= TW'(now_ms) + TW'(retention);
					code_q     <= (operation == rrst_pkg::OP_CLEAR) ? rrst_pkg::RC_ACQUIRED
						: rrst_pkg::RC_UNAVAILABLE;
					att_q      <= 5'd0;
					hint_q     <= 1'b0;
					hep_q      <= '0;
				end
			end
			rrst_pkg::ST_EVAL: begin
				free_idx_q <= free_idx_d;
				if (hit && !replace) begin
					sel_idx_q <= idx_q;
					cur_q     <= rd_data;
				end else if (replace) begin
					sel_idx_q <= idx_q;
					cur_q     <= fresh;
				end else if (is_last) begin
					sel_idx_q <= free_idx_d;
					cur_q     <= fresh;
					code_q    <= rrst_pkg::RC_BUSY;
					att_q     <= 5'd0;
					hint_q    <= 1'b0;
					hep_q     <= '0;
				end
			end
			rrst_pkg::ST_APPLY: begin
				code_q <= upd_code;
				att_q  <= upd_used ? upd.attempts : 5'd0;
				hint_q <= upd_hint;
				hep_q  <= upd_hint ? cur_q.endpoint : 64'd0;
			end
			rrst_pkg::ST_READ, rrst_pkg::ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	assign in_stall      = (state_q != rrst_pkg::ST_IDLE);
	assign out_valid     = (state_q == rrst_pkg::ST_OUT);
	assign result_code   = code_q;
	assign attempt_count = att_q;
	assign hint_issue    = hint_q;
	assign hint_endpoint = hep_q;

endmodule

>>> bench/tb_route_retry_slot_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Route retry slot table testbench
// Sends directed and random route requests and table clears. A predictor
// mirrors the slot table and checks every result beat in order. Requests
// and results both idle and stall at random, and the table is
// reconfigured between phases.
// ----------------------------------------------------------------------------
module tb_route_retry_slot_table;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES    = 40;
	localparam int KEY_POOL       = 24;

	typedef struct packed {
		logic [2:0]  code;
		logic [4:0]  attempts;
		logic        hint;
		logic [63:0] hint_ep;
	} route_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        operation;
	logic [63:0] pairing_key;
	logic [63:0] endpoint_key;
	logic [2:0]  observation;
	logic        resource_grant;
	logic        hint_accepted;
	logic [47:0] now_ms;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  result_code;
	logic [4:0]  attempt_count;
	logic        hint_issue;
	logic [63:0] hint_endpoint;

	route_result_t expected_results[$];
	int  error_count;
	bit  idle_en;
	int  stall_left;
	int  quiet_cycles;

	// Shadow configuration and slot table.
	logic [31:0]                 lifetime_cfg;
	logic [31:0]                 retention_cfg;
	logic [4:0]                  limit_cfg;
	logic [15:0]                 backoff_cfg;
	logic                        sh_used[rrst_pkg::SLOT_COUNT];
	logic                        sh_term[rrst_pkg::SLOT_COUNT];
	logic [2:0]                  sh_code[rrst_pkg::SLOT_COUNT];
	logic [63:0]                 sh_key[rrst_pkg::SLOT_COUNT];
	logic [63:0]                 sh_ep[rrst_pkg::SLOT_COUNT];
	logic [rrst_pkg::TIME_W-1:0] sh_deadline[rrst_pkg::SLOT_COUNT];
	logic [rrst_pkg::TIME_W-1:0] sh_next_try[rrst_pkg::SLOT_COUNT];
	logic [4:0]                  sh_attempts[rrst_pkg::SLOT_COUNT];

	logic [63:0] key_pool[KEY_POOL];
	logic [63:0] ep_pool[KEY_POOL][2];
	logic [47:0] clock_ms;

	route_retry_slot_table dut (.*);

	// Clock and reset.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Table shadow helpers.
	function automatic void wipe_shadow_slot(int i);
		sh_used[i]     = 1'b0;
		sh_term[i]     = 1'b0;
		sh_code[i]     = rrst_pkg::RC_ACQUIRED;
		sh_key[i]      = '0;
		sh_ep[i]       = '0;
		sh_deadline[i] = '0;
		sh_next_try[i] = '0;
		sh_attempts[i] = '0;
	endfunction

	// Scan for the slot of a key, expiring and allocating as the block does.
	function automatic int claim_route_slot(logic [63:0] k, logic [63:0] ep,
			logic [47:0] now);
		int free_idx;
		int hit;
		bit stop;
		free_idx = -1;
		hit = -1;
		stop = 1'b0;
		for (int i = 0; i < rrst_pkg::SLOT_COUNT; i++) begin
			if (!stop) begin
				if (sh_used[i] && sh_key[i] == k) begin
					if ((sh_term[i] && {1'b0, now} >= sh_deadline[i]) || sh_ep[i] != ep) begin
						wipe_shadow_slot(i);
						free_idx = i;
					end else begin
						hit = i;
					end
					stop = 1'b1;
				end else if (sh_used[i] && {1'b0, now} >= sh_deadline[i]) begin
					wipe_shadow_slot(i);
					if (free_idx < 0) free_idx = i;
				end else if (!sh_used[i] && free_idx < 0) begin
					free_idx = i;
				end
			end
		end
		if (hit >= 0) return hit;
		if (free_idx < 0) return -1;
		wipe_shadow_slot(free_idx);
		sh_used[free_idx]     = 1'b1;
		sh_key[free_idx]      = k;
		sh_ep[free_idx]       = ep;
		sh_deadline[free_idx] = {1'b0, now} + lifetime_cfg;
		return free_idx;
	endfunction

	// Expected result of one request, updating the shadow table.
	function automatic route_result_t predict_route(logic op, logic [63:0] k,
			logic [63:0] ep, logic [2:0] obs, logic adm, logic acc, logic [47:0] now);
		route_result_t r;
		int idx;
		logic [63:0] delay;
		r = '0;
		if (op == rrst_pkg::OP_CLEAR) begin
			for (int i = 0; i < rrst_pkg::SLOT_COUNT; i++) wipe_shadow_slot(i);
			r.code = rrst_pkg::RC_ACQUIRED;
			return r;
		end
		if (now == '0) begin
			r.code = rrst_pkg::RC_UNAVAILABLE;
			return r;
		end
		idx = claim_route_slot(k, ep, now);
		if (idx < 0) begin
			r.code = rrst_pkg::RC_BUSY;
			return r;
		end
		if (sh_term[idx]) begin
			r.code = sh_code[idx];
		end else if (obs == rrst_pkg::OBS_MATCHED) begin
			wipe_shadow_slot(idx);
			r.code = rrst_pkg::RC_ACQUIRED;
		end else if (obs == rrst_pkg::OBS_WRONG || obs == rrst_pkg::OBS_PLAIN) begin
			sh_term[idx]     = 1'b1;
			sh_code[idx]     = (obs == rrst_pkg::OBS_WRONG) ? rrst_pkg::RC_MISMATCH
				: rrst_pkg::RC_DOWNGRADE;
			sh_deadline[idx] = {1'b0, now} + retention_cfg;
			r.code = sh_code[idx];
		end else if (obs == rrst_pkg::OBS_CONNECTING) begin
			r.code = rrst_pkg::RC_PENDING;
		end else if ({1'b0, now} >= sh_deadline[idx]) begin
			sh_term[idx]     = 1'b1;
			sh_code[idx]     = rrst_pkg::RC_EXHAUSTED;
			sh_deadline[idx] = {1'b0, now} + retention_cfg;
			r.code = rrst_pkg::RC_EXHAUSTED;
		end else if (sh_attempts[idx] >= limit_cfg) begin
			r.code = rrst_pkg::RC_PENDING;
		end else if ({1'b0, now} < sh_next_try[idx]) begin
			r.code = rrst_pkg::RC_PENDING;
		end else if (!adm || !acc) begin
			r.code = rrst_pkg::RC_DEFERRED;
		end else begin
			// Hint issued; the retry delay doubles with each attempt.
			sh_attempts[idx] = sh_attempts[idx] + 5'd1;
			delay = {48'd0, backoff_cfg} << ((sh_attempts[idx] - 5'd1) & 5'd31);
			sh_next_try[idx] = {1'b0, now} + delay[rrst_pkg::TIME_W-1:0];
			r.code    = rrst_pkg::RC_PENDING;
			r.hint    = 1'b1;
			r.hint_ep = sh_ep[idx];
		end
		if (sh_used[idx]) r.attempts = sh_attempts[idx];
		return r;
	endfunction

	// Sends one request beat and records its expected result.
	task automatic send_request(logic op, logic [63:0] k, logic [63:0] ep,
			logic [2:0] obs, logic adm, logic acc, logic [47:0] now);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid       <= 1'b1;
		operation      <= op;
		pairing_key    <= k;
		endpoint_key   <= ep;
		observation    <= obs;
		resource_grant <= adm;
		hint_accepted  <= acc;
		now_ms         <= now;
		do @(posedge clk); while (in_stall);
		expected_results.push_back(predict_route(op, k, ep, obs, adm, acc, now));
	endtask

	task automatic step_route(logic [63:0] k, logic [63:0] ep, logic [2:0] obs,
			logic adm, logic acc);
		send_request(rrst_pkg::OP_STEP, k, ep, obs, adm, acc, clock_ms);
	endtask

	// Waits until every expected result beat has arrived.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// Writes all four registers while the table is idle.
	task automatic set_config(logic [31:0] lifetime, logic [31:0] retention,
			logic [4:0] limit, logic [15:0] backoff);
		logic [31:0] vals[4];
		logic [1:0] idx[4];
		drain_results();
		vals = '{lifetime, retention, {27'd0, limit}, {16'd0, backoff}};
		idx  = '{rrst_pkg::CFG_LIFETIME, rrst_pkg::CFG_RETENTION, rrst_pkg::CFG_LIMIT,
			rrst_pkg::CFG_BACKOFF};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		lifetime_cfg  = lifetime;
		retention_cfg = retention;
		limit_cfg     = limit;
		backoff_cfg   = backoff;
	endtask

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
		error_count++;
	endtask

	// Result checker: one beat per accepted result.
	always @(posedge clk) begin
		route_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected beat", {61'd0, result_code}, 64'd0);
			end else begin
				want = expected_results.pop_front();
				if (result_code !== want.code)
					report_mismatch("result_code", {61'd0, result_code}, {61'd0, want.code});
				if (attempt_count !== want.attempts)
					report_mismatch("attempt_count", {59'd0, attempt_count},
						{59'd0, want.attempts});
				if (hint_issue !== want.hint)
					report_mismatch("hint_issue", {63'd0, hint_issue}, {63'd0, want.hint});
				if (hint_endpoint !== want.hint_ep)
					report_mismatch("hint_endpoint", hint_endpoint, want.hint_ep);
			end
		end
	end

	// Result stall in random bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (!idle_en) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= (stall_left != 1);
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(1, 13);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog on cycles with no beat on any channel.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Clear, zero time and key extremes.
	task automatic test_clear_and_zero_time();
		send_request(rrst_pkg::OP_CLEAR, '1, '1, 3'd7, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF);
		send_request(rrst_pkg::OP_STEP, '1, '1, 3'd0, 1'b1, 1'b1, 48'd0);
		clock_ms = 48'd10;
		step_route(64'd0, 64'd0, 3'd0, 1'b1, 1'b1);
		step_route('1, '1, 3'd0, 1'b1, 1'b1);
		send_request(rrst_pkg::OP_CLEAR, 64'd0, 64'd0, 3'd0, 1'b0, 1'b0, 48'd0);
	endtask

	// Every observation, including the codes that act like none.
	task automatic test_observations();
		for (int o = 0; o < 8; o++) begin
			clock_ms += 48'd5;
			step_route(64'h100 + o, 64'h200 + o, 3'(o), 1'b1, 1'b1);
			step_route(64'h100 + o, 64'h200 + o, 3'd0, 1'b1, 1'b1);
		end
		// A new endpoint replaces the slot of the same key.
		step_route(64'h100, 64'h999, 3'd0, 1'b1, 1'b1);
	endtask

	// Backoff, attempt cap, deferral, lifetime and retention expiry.
	task automatic test_retry_backoff();
		set_config(32'd40, 32'd6, 5'd2, 16'd1);
		clock_ms = 48'd1000;
		step_route(64'hA, 64'hB, 3'd0, 1'b0, 1'b1);
		step_route(64'hA, 64'hB, 3'd0, 1'b1, 1'b0);
		step_route(64'hA, 64'hB, 3'd0, 1'b1, 1'b1);
		step_route(64'hA, 64'hB, 3'd0, 1'b1, 1'b1);
		clock_ms += 48'd1;
		step_route(64'hA, 64'hB, 3'd0, 1'b1, 1'b1);
		clock_ms += 48'd5;
		step_route(64'hA, 64'hB, 3'd0, 1'b1, 1'b1);
		clock_ms += 48'd40;
		step_route(64'hA, 64'hB, 3'd0, 1'b1, 1'b1);
		step_route(64'hA, 64'hB, 3'd2, 1'b1, 1'b1);
		clock_ms += 48'd6;
		step_route(64'hA, 64'hB, 3'd0, 1'b1, 1'b1);
	endtask

	// Sixteen live slots leave no room for another key.
	task automatic test_table_full();
		set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd16, 16'hFFFF);
		for (int i = 0; i < rrst_pkg::SLOT_COUNT; i++)
			step_route(64'h5000 + i, 64'h6000 + i, 3'd1, 1'b0, 1'b0);
		step_route(64'h7777, 64'h8888, 3'd0, 1'b1, 1'b1);
		send_request(rrst_pkg::OP_CLEAR, 64'd0, 64'd0, 3'd0, 1'b0, 1'b0, clock_ms);
	endtask

	// Random requests over a small key pool under one configuration.
	task automatic test_random_phase(int count, logic [47:0] start_ms, int max_adv);
		int  k;
		int  pick;
		logic [2:0] obs;
		logic [47:0] now;
		clock_ms = start_ms;
		for (int n = 0; n < count; n++) begin
			k = $urandom_range(0, KEY_POOL - 1);
			pick = $urandom_range(0, 99);
			if (pick < 40) obs = 3'd0;
			else if (pick < 60) obs = rrst_pkg::OBS_CONNECTING;
			else if (pick < 75) obs = rrst_pkg::OBS_MATCHED;
			else if (pick < 83) obs = rrst_pkg::OBS_WRONG;
			else if (pick < 91) obs = rrst_pkg::OBS_PLAIN;
			else obs = 3'($urandom_range(5, 7));
			if ($urandom_range(0, 3) == 0 && clock_ms < 48'hFFFF_FFFF_0000)
				clock_ms += 48'($urandom_range(0, max_adv));
			now = ($urandom_range(0, 40) == 0) ? 48'd0 : clock_ms;
			if ($urandom_range(0, 60) == 0)
				send_request(rrst_pkg::OP_CLEAR, key_pool[k], ep_pool[k][0], obs, 1'b1, 1'b1,
					now);
			else
				send_request(rrst_pkg::OP_STEP, key_pool[k],
					ep_pool[k][$urandom_range(0, 9) == 0],
					obs, $urandom_range(0, 5) != 0, $urandom_range(0, 5) != 0, now);
			if (n == count / 2 && $urandom_range(0, 1) == 0) drain_results();
		end
	endtask

	initial begin
		arst_n         <= 1'b0;
		cfg_valid      <= 1'b0;
		cfg_index      <= rrst_pkg::CFG_LIFETIME;
		cfg_data       <= '0;
		in_valid       <= 1'b0;
		operation      <= rrst_pkg::OP_STEP;
		pairing_key    <= '0;
		endpoint_key   <= '0;
		observation    <= '0;
		resource_grant <= 1'b0;
		hint_accepted  <= 1'b0;
		now_ms         <= '0;
		error_count  = 0;
		quiet_cycles = 0;
		idle_en      = 1'b1;
		lifetime_cfg  = 32'd60000;
		retention_cfg = 32'd30000;
		limit_cfg     = 5'd4;
		backoff_cfg   = 16'd1000;
		for (int i = 0; i < rrst_pkg::SLOT_COUNT; i++) wipe_shadow_slot(i);
		for (int i = 0; i < KEY_POOL; i++) begin
			key_pool[i]   = {$urandom, $urandom};
			ep_pool[i][0] = {$urandom, $urandom};
			ep_pool[i][1] = ~ep_pool[i][0];
		end
		key_pool[0] = '1;
		key_pool[1] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_clear_and_zero_time();
		test_observations();
		test_retry_backoff();
		test_table_full();

		// Random phases, including the odd attempt limits and zero backoff.
		drain_results();
		test_random_phase(120, 48'd1, 3000);
		set_config(32'd50, 32'd20, 5'd16, 16'd1);
		test_random_phase(120, 48'd100, 30);
		set_config(32'd1, 32'd1, 5'd1, 16'hFFFF);
		test_random_phase(100, 48'd7, 3);
		set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0, 16'd0);
		test_random_phase(100, 48'hFFFF_FFFF_0000, 1000);
		set_config(32'd300, 32'd100, 5'd31, 16'd3);
		test_random_phase(130, 48'hFFFF_0000_0000, 200);
		drain_results();
		idle_en = 1'b0;
		test_random_phase(130, 48'd500, 60);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/rrst_pkg.sv
rtl/core/rrst_store.sv
rtl/core/rrst_ctrl.sv
rtl/core/route_retry_slot_table.sv
bench/tb_route_retry_slot_table.sv
